// ===== rtl/lanc_pkg.sv =====
package lanc_pkg;

	// frame geometry
	localparam int FRAME_BYTES = 8;
	localparam int TX_BYTES    = 2;
	localparam int TOTAL_BITS  = FRAME_BYTES * 8;
	localparam int TX_BITS     = TX_BYTES * 8;

	// field and counter widths
	localparam int BT_W    = 10;
	localparam int ST_W    = 16;
	localparam int TMR_W   = 16;
	localparam int THR_W   = 14;
	localparam int BC_W    = $clog2(TOTAL_BITS + 1);
	localparam int TXI_W   = $clog2(TX_BITS);
	localparam int SLOT_W  = 3;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 16;

	// register reset values
	localparam logic [BT_W-1:0] BIT_TICKS_RST  = BT_W'(104);
	localparam logic [ST_W-1:0] SYNC_TICKS_RST = ST_W'(3000);

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_CMD_BYTE0  = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_CMD_BYTE1  = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_BIT_TICKS  = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_SYNC_TICKS = CFG_IW'(3);

	typedef enum logic [2:0] {
		PH_SYNC       = 3'd0,
		PH_WAIT_START = 3'd1,
		PH_TX_BIT     = 3'd2,
		PH_TX_STOP    = 3'd3,
		PH_WAIT_NEXT  = 3'd4,
		PH_RX_BIT     = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]      cmd_byte0;
		logic [7:0]      cmd_byte1;
		logic [BT_W-1:0] bit_ticks;
		logic [ST_W-1:0] sync_ticks;
	} cfg_t;

	typedef struct packed {
		logic              line_out;
		logic              rx_valid;
		logic [7:0]        rx_byte;
		logic [SLOT_W-1:0] rx_slot;
		logic              frame_done;
	} res_t;

	// command bytes packed into the transmit frame, bytes past the second send zero
	function automatic logic [TX_BITS-1:0] tx_frame_f(logic [7:0] c0, logic [7:0] c1);
		logic [31:0] w;
		w = {16'h0000, c1, c0};
		return w[TX_BITS-1:0];
	endfunction

endpackage

// ===== rtl/lanc_in_if.sv =====
interface lanc_in_if;
	logic valid;
	logic ready;
	logic line_in;

	modport source (output valid, output line_in, input ready);
	modport sink (input valid, input line_in, output ready);
endinterface

// ===== rtl/lanc_out_if.sv =====
interface lanc_out_if;
	logic                          valid;
	logic                          ready;
	logic                          line_out;
	logic                          rx_valid;
	logic [7:0]                    rx_byte;
	logic [lanc_pkg::SLOT_W-1:0]   rx_slot;
	logic                          frame_done;

	modport source (output valid, output line_out, output rx_valid, output rx_byte,
		output rx_slot, output frame_done, input ready);
	modport sink (input valid, input line_out, input rx_valid, input rx_byte,
		input rx_slot, input frame_done, output ready);
endinterface

// ===== rtl/lanc_fsm.sv =====
module lanc_fsm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            line,
	input  lanc_pkg::cfg_t  cfg,
	output lanc_pkg::res_t  res
);

	lanc_pkg::phase_t                  phase_q, phase_d;
	logic [lanc_pkg::TMR_W-1:0]        timer_q, timer_d, timer_inc;
	logic [lanc_pkg::BC_W-1:0]         bit_count_q, bit_count_d, bit_count_inc;
	logic [lanc_pkg::TX_BITS-1:0]      tx_frame_q, tx_frame_d;
	logic [7:0]                        rx_shift_q, rx_shift_d, rx_merged;
	logic                              drive_q, drive_d;

	logic [2:0]                        bit_nr;
	logic [lanc_pkg::THR_W-1:0]        thr_tx, thr_rx, thr_stop, thr_gap, half_bit;
	logic                              hit_tx, hit_rx, hit_stop, hit_gap;
	logic                              last_bit, frame_end;
	logic [lanc_pkg::BC_W-1:0]         slot_full;
	logic                              tx_bit_val;

	// saturating tick counter and bit position
	assign timer_inc     = (timer_q == '1) ? timer_q : timer_q + 1'b1;
	assign bit_nr        = bit_count_q[2:0];
	assign bit_count_inc = bit_count_q + 1'b1;
	assign last_bit      = (bit_nr == 3'd7);
	assign frame_end     = (bit_count_inc >= lanc_pkg::BC_W'(lanc_pkg::TOTAL_BITS));
	assign slot_full     = bit_count_q >> 3;

	// bit timing thresholds
	assign half_bit = lanc_pkg::THR_W'(cfg.bit_ticks >> 1);
	assign thr_tx   = lanc_pkg::THR_W'({1'b0, bit_nr} + 4'd1) * lanc_pkg::THR_W'(cfg.bit_ticks);
	assign thr_rx   = thr_tx + half_bit;
	assign thr_stop = lanc_pkg::THR_W'(cfg.bit_ticks) * lanc_pkg::THR_W'(9);
	assign thr_gap  = lanc_pkg::THR_W'(cfg.bit_ticks) * lanc_pkg::THR_W'(10) - half_bit;

	assign hit_tx   = (timer_inc >= lanc_pkg::TMR_W'(thr_tx));
	assign hit_rx   = (timer_inc >= lanc_pkg::TMR_W'(thr_rx));
	assign hit_stop = (timer_inc >= lanc_pkg::TMR_W'(thr_stop));
	assign hit_gap  = (timer_inc > lanc_pkg::TMR_W'(thr_gap));

	// transmit bit and receive merge
	assign tx_bit_val = (bit_count_q < lanc_pkg::BC_W'(lanc_pkg::TX_BITS))
		? tx_frame_q[bit_count_q[lanc_pkg::TXI_W-1:0]] : 1'b0;
	assign rx_merged  = rx_shift_q | (8'(line) << bit_nr);

	// next state
	always_comb begin
		phase_d     = phase_q;
		timer_d     = timer_inc;
		bit_count_d = bit_count_q;
		tx_frame_d  = tx_frame_q;
		rx_shift_d  = rx_shift_q;
		drive_d     = drive_q;
		unique case (phase_q)
			lanc_pkg::PH_SYNC: begin
				if (!line) begin
					timer_d = '0;
				end else if (timer_inc >= cfg.sync_ticks) begin
					tx_frame_d = lanc_pkg::tx_frame_f(cfg.cmd_byte0, cfg.cmd_byte1);
					phase_d    = lanc_pkg::PH_WAIT_START;
				end
			end
			lanc_pkg::PH_WAIT_START: begin
				if (!line) begin
					bit_count_d = '0;
					timer_d     = '0;
					rx_shift_d  = '0;
					phase_d     = lanc_pkg::PH_TX_BIT;
				end
			end
			lanc_pkg::PH_TX_BIT: begin
				if (hit_tx) begin
					drive_d     = tx_bit_val;
					bit_count_d = bit_count_inc;
					if (last_bit) begin
						phase_d = lanc_pkg::PH_TX_STOP;
					end
				end
			end
			lanc_pkg::PH_TX_STOP: begin
				if (hit_stop) begin
					drive_d = 1'b0;
					if (bit_count_q >= lanc_pkg::BC_W'(lanc_pkg::TOTAL_BITS)) begin
						timer_d = '0;
						phase_d = lanc_pkg::PH_SYNC;
					end else begin
						phase_d = lanc_pkg::PH_WAIT_NEXT;
					end
				end
			end
			lanc_pkg::PH_WAIT_NEXT: begin
				if (hit_gap && !line) begin
					timer_d    = '0;
					rx_shift_d = '0;
					phase_d    = (bit_count_q < lanc_pkg::BC_W'(lanc_pkg::TX_BITS))
						? lanc_pkg::PH_TX_BIT : lanc_pkg::PH_RX_BIT;
				end
			end
			lanc_pkg::PH_RX_BIT: begin
				if (hit_rx) begin
					rx_shift_d  = rx_merged;
					bit_count_d = bit_count_inc;
					if (last_bit) begin
						if (frame_end) begin
							timer_d = '0;
							phase_d = lanc_pkg::PH_SYNC;
						end else begin
							phase_d = lanc_pkg::PH_WAIT_NEXT;
						end
					end
				end
			end
			default: begin
				timer_d = '0;
				phase_d = lanc_pkg::PH_SYNC;
			end
		endcase
	end

	// result of this tick
	always_comb begin
		res            = '0;
		res.line_out   = drive_d;
		unique case (phase_q)
			lanc_pkg::PH_TX_STOP: begin
				res.frame_done = hit_stop
					&& (bit_count_q >= lanc_pkg::BC_W'(lanc_pkg::TOTAL_BITS));
			end
			lanc_pkg::PH_RX_BIT: begin
				if (hit_rx && last_bit) begin
					res.rx_valid   = 1'b1;
					res.rx_byte    = rx_merged;
					res.rx_slot    = lanc_pkg::SLOT_W'(slot_full);
					res.frame_done = frame_end;
				end
			end
			default: begin
				res.frame_done = 1'b0;
			end
		endcase
	end

	// state registers, advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lanc_pkg::PH_SYNC;
			timer_q     <= '0;
			bit_count_q <= '0;
			tx_frame_q  <= '0;
			rx_shift_q  <= '0;
			drive_q     <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			timer_q     <= timer_d;
			bit_count_q <= bit_count_d;
			tx_frame_q  <= tx_frame_d;
			rx_shift_q  <= rx_shift_d;
			drive_q     <= drive_d;
		end
	end

	// a received byte only comes out of a receive slot
	a_rx_in_rx_slot: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.rx_valid |-> phase_q == lanc_pkg::PH_RX_BIT)
		else $error("rx byte outside receive slot");

	// end of frame goes straight back to sync search
	a_done_to_sync: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_done |=> phase_q == lanc_pkg::PH_SYNC && timer_q == '0)
		else $error("frame end did not return to sync");

	// bit counter never runs past the frame
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= lanc_pkg::BC_W'(lanc_pkg::TOTAL_BITS))
		else $error("bit count past frame length");

	// line is only driven inside a transmit slot
	a_drive_in_tx: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q |-> phase_q == lanc_pkg::PH_TX_BIT || phase_q == lanc_pkg::PH_TX_STOP)
		else $error("line driven outside transmit slot");

	// no tick, no state change
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(timer_q) && $stable(bit_count_q))
		else $error("state moved without a tick");

endmodule

// ===== rtl/lanc_frame_transceiver_top.sv =====
// Single-wire camera bus frame transceiver.
// in_ch carries one beat per time tick with the sampled bus level (line_in).
// out_ch returns exactly one beat per input beat: the level to drive on the
// pin (line_out), a received byte with its slot index when rx_valid is set,
// and frame_done on the tick the last slot of a frame finishes.
// The block waits for sync_ticks high ticks, latches cmd_byte0/cmd_byte1,
// then sends them LSB first in the first two slots and receives six bytes.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); writes
// to the command bytes take effect at the next sync, bit_ticks at once.
// A beat accepted into the input register is processed by the frame state
// machine, and its result is held and presented from the result register.
// Throughput: one beat per cycle while out_ch does not stall.
// If out_ch stalls, the pending result waits in its register, one more beat
// may be taken into the input register, then in_ch.ready drops until it drains.
// Reset (arst_n low) clears the frame state to sync search, idle line, and
// restores the register defaults; no beats are held after reset.
module lanc_frame_transceiver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	lanc_in_if.sink                       in_ch,
	lanc_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [lanc_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [lanc_pkg::CFG_DW-1:0]   cfg_wdata
);

	lanc_pkg::cfg_t  cfg_q;
	lanc_pkg::res_t  res;
	lanc_pkg::res_t  res_q;
	logic            valid_s1;
	logic            line_s1;
	logic            out_valid_q;
	logic            step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_byte0  <= '0;
			cfg_q.cmd_byte1  <= '0;
			cfg_q.bit_ticks  <= lanc_pkg::BIT_TICKS_RST;
			cfg_q.sync_ticks <= lanc_pkg::SYNC_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lanc_pkg::REG_CMD_BYTE0:  cfg_q.cmd_byte0  <= cfg_wdata[7:0];
				lanc_pkg::REG_CMD_BYTE1:  cfg_q.cmd_byte1  <= cfg_wdata[7:0];
				lanc_pkg::REG_BIT_TICKS:  cfg_q.bit_ticks  <= cfg_wdata[lanc_pkg::BT_W-1:0];
				lanc_pkg::REG_SYNC_TICKS: cfg_q.sync_ticks <= cfg_wdata[lanc_pkg::ST_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: process when a beat is held and the result slot is free
	assign step        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			line_s1 <= in_ch.line_in;
		end
	end

	// frame state machine
	lanc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.line   (line_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.line_out   = res_q.line_out;
	assign out_ch.rx_valid   = res_q.rx_valid;
	assign out_ch.rx_byte    = res_q.rx_byte;
	assign out_ch.rx_slot    = res_q.rx_slot;
	assign out_ch.frame_done = res_q.frame_done;

endmodule
